>>> sv/crc32_with_zeroed_field_macros.svh
// Assertion macros for the CRC-32 block with a zeroed checksum field.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef CRC32_WITH_ZEROED_FIELD_MACROS_SVH
`define CRC32_WITH_ZEROED_FIELD_MACROS_SVH

`ifndef SYNTH
// Check that an expression holds at every clock edge outside reset
`define CWZF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: expression does not hold");
// Check that a consequent holds whenever an antecedent holds
`define CWZF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define CWZF_ASSERT_ALWAYS(lbl, expr)
`define CWZF_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> sv/cwzf_pkg.sv
// Package for the CRC-32 block with a zeroed checksum field.
// Holds widths, constants, the queue entry type and the byte-wide CRC update.
`timescale 1ns / 1ps

package cwzf_pkg;

  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CRC_W    = 32;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] POS_MAX      = 11'd2047;
  localparam logic [POS_W-1:0] FIELD_LEN    = 11'd4;

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] data;       // already zeroed inside the field window
    logic              restart;    // start a new checksum before this byte
    logic              last;       // emit the finished checksum after this byte
    logic              short_img;  // image ended before the window was complete
  } cwzf_item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } cwzf_qstat_t;

  // Reflected CRC-32 update over one byte, unrolled over its eight bits
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [DATA_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
    for (int k = 0; k < DATA_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/cwzf_if.sv
// Channel interfaces for the CRC-32 block: image bytes in, checksums out.
// Depends on cwzf_pkg for the field widths.
`timescale 1ns / 1ps

interface cwzf_in_if;
  logic                        valid;
  logic                        ready;
  logic [cwzf_pkg::DATA_W-1:0] data_byte;
  logic                        first_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface cwzf_out_if;
  logic                       valid;
  logic                       ready;
  logic [cwzf_pkg::CRC_W-1:0] checksum;
  logic                       short_image;

  modport source (output valid, output checksum, output short_image, input ready);
  modport sink (input valid, input checksum, input short_image, output ready);
endinterface

>>> sv/cwzf_front.sv
// Front end: accepts image bytes, tracks the byte position, zeroes the field
// window and computes the short-image flag. Depends on cwzf_pkg, cwzf_if.
`timescale 1ns / 1ps

module cwzf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwzf_pkg::OFFSET_W-1:0] cfg_wdata,
  cwzf_in_if.sink                       in_ch,
  input  cwzf_pkg::cwzf_qstat_t         q_stat,
  output logic                          push,
  output cwzf_pkg::cwzf_item_t          push_item
);
  import cwzf_pkg::*;

  logic [OFFSET_W-1:0] offset_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    pos_cur, win_start, win_end, length;
  logic                in_window;

  // Accept whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the byte against the field window
  always_comb begin
    pos_cur   = in_ch.first_byte ? '0 : pos_r;
    win_start = {1'b0, offset_r};
    win_end   = win_start + FIELD_LEN;
    in_window = (pos_cur >= win_start) && (pos_cur < win_end);
    length    = (pos_cur < POS_MAX) ? pos_cur + 11'd1 : POS_MAX;

    push_item.data      = in_window ? '0 : in_ch.data_byte;
    push_item.restart   = in_ch.first_byte;
    push_item.last      = in_ch.last_byte;
    push_item.short_img = length < win_end;

    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_ch.last_byte ? '0 : length;
    end
  end

  // Hold the offset register and the byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      pos_r    <= '0;
    end else begin
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> sv/cwzf_queue.sv
// Two-entry queue of classified bytes between the front and the back.
// Depends on cwzf_pkg for the entry type.
`timescale 1ns / 1ps

module cwzf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cwzf_pkg::cwzf_item_t  push_item,
  input  logic                  pop,
  output cwzf_pkg::cwzf_item_t  head,
  output cwzf_pkg::cwzf_qstat_t stat
);
  import cwzf_pkg::*;

  cwzf_item_t  entry_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign head       = entry_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  // Store incoming entries; no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> sv/cwzf_back.sv
// Back end: runs the CRC-32 update on queued bytes and holds the finished
// checksum in an output register. Depends on cwzf_pkg, cwzf_if.
`timescale 1ns / 1ps

module cwzf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cwzf_pkg::cwzf_item_t  head,
  input  cwzf_pkg::cwzf_qstat_t q_stat,
  output logic                  pop,
  cwzf_out_if.source            out_ch
);
  import cwzf_pkg::*;

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_base, crc_new;
  logic             out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0] checksum_r;
  logic             short_r;
  logic             emit;

  // Pop unless a final byte would overwrite an untaken result
  assign pop  = !q_stat.empty && (!head.last || !out_valid_r || out_ch.ready);
  assign emit = pop && head.last;

  always_comb begin
    crc_base = head.restart ? CRC_ALL_ONES : crc_r;
    crc_new  = crc_byte(crc_base, head.data);
    crc_nxt  = crc_r;
    if (pop) begin
      crc_nxt = head.last ? CRC_ALL_ONES : crc_new;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Hold the running CRC and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_ALL_ONES;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on a final byte
  always_ff @(posedge clk) begin
    if (emit) begin
      checksum_r <= crc_new ^ CRC_ALL_ONES;
      short_r    <= head.short_img;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.checksum    = checksum_r;
  assign out_ch.short_image = short_r;

endmodule

>>> sv/crc32_with_zeroed_field.sv
// Reflected CRC-32 (polynomial 0xEDB88320, init and final XOR all ones) over
// an image streamed one byte per transaction, with the four bytes at
// cfg_wdata's offset fed in as zeros. Throughput is one byte per clock when
// neither side stalls: the eight-bit CRC update is unrolled in the back end,
// and a two-entry queue between front and back lets input and output stall
// apart. The result of a last byte passes through the queue entry and then
// into an output register, where it is held until taken. No clearing pass
// follows reset. Write the offset only while no image is in flight.
`timescale 1ns / 1ps
`include "crc32_with_zeroed_field_macros.svh"

module crc32_with_zeroed_field (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwzf_pkg::OFFSET_W-1:0] cfg_wdata,
  cwzf_in_if.sink                       in_ch,
  cwzf_out_if.source                    out_ch
);
  import cwzf_pkg::*;

  logic        push, pop;
  cwzf_item_t  push_item, q_head;
  cwzf_qstat_t q_stat;

  cwzf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  cwzf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cwzf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // Never pop an empty queue
  `CWZF_ASSERT_IMPLY(a_no_pop_empty, pop, !q_stat.empty)
  // A final byte pops only when the output slot is free or being taken
  `CWZF_ASSERT_IMPLY(a_last_slot_free, pop && q_head.last, !out_ch.valid || out_ch.ready)
  // A full queue blocks the input
  `CWZF_ASSERT_IMPLY(a_full_blocks_in, q_stat.full, !in_ch.ready)

endmodule
